// ----- hw/rtl/lirs_pkg.sv -----
// Shared constants, codes and sequencer states for the LIRS replacement core.
package lirs_pkg;

    localparam int TRACK_ENTRIES_DEF = 256;
    localparam int ADDR_BITS_DEF     = 32;

    localparam int CACHE_BLOCKS_W = 9;
    localparam int LIR_LIMIT_W    = 8;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 9;

    localparam int CACHE_BLOCKS_RESET = 64;
    localparam int LIR_LIMIT_RESET    = CACHE_BLOCKS_RESET * 90 / 100;

    localparam logic [CFG_INDEX_W-1:0] REG_CACHE_BLOCKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIR_LIMIT    = 2'd1;

    // status word: bits 1..0 kind, bit 2 set while the entry sits in the stack
    localparam logic [1:0] K_LIR  = 2'd1;
    localparam logic [1:0] K_HRES = 2'd2;
    localparam logic [1:0] K_HNON = 2'd3;
    localparam int         ST_IN_S = 2;

    localparam logic LIST_S = 1'b0;
    localparam logic LIST_Q = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DISPATCH,
        ST_TOP_A,
        ST_TOP_B,
        ST_HR_A,
        ST_HR_B,
        ST_HR_C,
        ST_HN_B,
        ST_HN_C,
        ST_H_PRUNE,
        ST_FINISH,
        ST_M_CHK,
        ST_M_EV,
        ST_M_EV2,
        ST_M_NEW,
        ST_M_WALK,
        ST_M_INS,
        ST_M_XRD1,
        ST_M_XRD2,
        ST_M_LIRCHK,
        ST_M_QPUSH,
        ST_DM_A,
        ST_DM_B,
        ST_DM_C,
        ST_DM_D,
        ST_PR_A,
        ST_PR_B,
        ST_RM,
        ST_PU_A,
        ST_PU_B
    } state_t;

endpackage

// ----- hw/rtl/lirs_link_ram.sv -----
// Prev/next link memories of one doubly linked list, registered read.
module lirs_link_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH),
    parameter int IW    = $clog2(DEPTH + 1)
) (
    input  logic          clk,
    input  logic [AW-1:0] raddr,
    output logic [IW-1:0] prev_rd,
    output logic [IW-1:0] next_rd,
    input  logic          prev_we,
    input  logic [AW-1:0] prev_waddr,
    input  logic [IW-1:0] prev_wdata,
    input  logic          next_we,
    input  logic [AW-1:0] next_waddr,
    input  logic [IW-1:0] next_wdata
);

    logic [IW-1:0] prev_mem [DEPTH];
    logic [IW-1:0] next_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        prev_rd <= prev_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        next_rd <= next_mem[raddr];
    end

endmodule

// ----- hw/rtl/lirs_replacement_policy_core.sv -----
// LIRS replacement core: tracking table, recency stack S and resident-HIR queue Q.
// Each input transaction is one block access; one result transaction follows with the
// hit flag and, on a miss, the evicted block. Items are handled one at a time. The tag
// lookup scans the tag memory one entry per cycle, and a hit stops the scan at the
// matching entry. List relinking then goes through the one-read-port link and status
// memories; every entry pruned from the stack bottom and, when the table is full, every
// stack entry walked adds to the cost. No clearing pass is needed after reset: entries
// carry valid flops.
module lirs_replacement_policy_core
    import lirs_pkg::*;
#(
    parameter int TRACK_ENTRIES = TRACK_ENTRIES_DEF,
    parameter int ADDR_BITS     = ADDR_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,   // [31:0] block_address
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [39:0]            m_axis_tdata    // [0] hit, [1] evict_valid,
                                                   // [33:2] evict_address, [39:34] zero
);

    localparam int AW = $clog2(TRACK_ENTRIES);
    localparam int IW = $clog2(TRACK_ENTRIES + 1);
    localparam int KW = (IW > CACHE_BLOCKS_W) ? IW : CACHE_BLOCKS_W;
    localparam logic [IW-1:0] NIL = IW'(TRACK_ENTRIES);

    // configuration
    logic [CACHE_BLOCKS_W-1:0] cache_blocks_reg;
    logic [LIR_LIMIT_W-1:0]    lir_limit_reg;

    // sequencer
    state_t state_reg, state_next;
    state_t leaf_ret_reg, leaf_ret_next;
    state_t prune_ret_reg, prune_ret_next;
    state_t demote_ret_reg, demote_ret_next;
    state_t top_ret_reg, top_ret_next;
    logic          lsel_reg, lsel_next;
    logic [AW-1:0] li_reg, li_next;
    logic [IW-1:0] ctr_reg, ctr_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] idx_d_reg, idx_d_next;

    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [IW-1:0] x_reg, x_next;
    logic          found_reg, found_next;
    logic [2:0]    xstat_reg, xstat_next;
    logic [IW-1:0] free_reg, free_next;
    logic          hit_reg, hit_next;
    logic          ev_valid_reg, ev_valid_next;
    logic [31:0]   ev_addr_reg, ev_addr_next;

    logic [IW-1:0] s_head_reg, s_head_next, s_tail_reg, s_tail_next;
    logic [IW-1:0] q_head_reg, q_head_next, q_tail_reg, q_tail_next;
    logic [IW-1:0] lir_cnt_reg, lir_cnt_next, hir_cnt_reg, hir_cnt_next;
    logic [TRACK_ENTRIES-1:0] valid_reg, valid_next;

    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg, out_data_next;

    // tag and status memories
    logic [ADDR_BITS-1:0] tag_mem [TRACK_ENTRIES];
    logic [2:0]           stat_mem [TRACK_ENTRIES];
    logic [ADDR_BITS-1:0] tag_rd_reg;
    logic [2:0]           stat_rd_reg;
    logic [AW-1:0]        ts_raddr;
    logic                 tg_we;
    logic                 st_we;
    logic [AW-1:0]        st_waddr;
    logic [2:0]           st_wdata;

    // link memory ports
    logic [IW-1:0] s_prev_rd, s_next_rd, q_prev_rd, q_next_rd;
    logic          s_prev_we, s_next_we, q_prev_we, q_next_we;
    logic [AW-1:0] prev_waddr, next_waddr;
    logic [IW-1:0] prev_wdata, next_wdata;

    // effective configuration
    logic [KW-1:0] cap_eff;
    logic [KW-1:0] lim_eff;

    always_comb
    begin
        cap_eff = KW'(cache_blocks_reg);
        if (cap_eff < KW'(2))
        begin
            cap_eff = KW'(2);
        end
        if (cap_eff > KW'(TRACK_ENTRIES))
        begin
            cap_eff = KW'(TRACK_ENTRIES);
        end
        lim_eff = KW'(lir_limit_reg);
        if (lim_eff < KW'(1))
        begin
            lim_eff = KW'(1);
        end
        if (lim_eff > cap_eff - KW'(1))
        begin
            lim_eff = cap_eff - KW'(1);
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        logic [IW-1:0]   p;
        logic [IW-1:0]   n;
        logic [IW-1:0]   t;
        logic [IW:0]     used;
        logic            drop;
        logic [AW-1:0]   drop_idx;

        state_next      = state_reg;
        leaf_ret_next   = leaf_ret_reg;
        prune_ret_next  = prune_ret_reg;
        demote_ret_next = demote_ret_reg;
        top_ret_next    = top_ret_reg;
        lsel_next       = lsel_reg;
        li_next         = li_reg;
        ctr_next        = ctr_reg;
        pend_next       = pend_reg;
        idx_d_next      = idx_d_reg;
        addr_next       = addr_reg;
        x_next          = x_reg;
        found_next      = found_reg;
        xstat_next      = xstat_reg;
        free_next       = free_reg;
        hit_next        = hit_reg;
        ev_valid_next   = ev_valid_reg;
        ev_addr_next    = ev_addr_reg;
        s_head_next     = s_head_reg;
        s_tail_next     = s_tail_reg;
        q_head_next     = q_head_reg;
        q_tail_next     = q_tail_reg;
        lir_cnt_next    = lir_cnt_reg;
        hir_cnt_next    = hir_cnt_reg;
        valid_next      = valid_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg & ~m_axis_tready;

        tg_we      = 1'b0;
        st_we      = 1'b0;
        st_waddr   = li_reg;
        st_wdata   = 3'b000;
        s_prev_we  = 1'b0;
        s_next_we  = 1'b0;
        q_prev_we  = 1'b0;
        q_next_we  = 1'b0;
        prev_waddr = li_reg;
        next_waddr = li_reg;
        prev_wdata = NIL;
        next_wdata = NIL;
        drop       = 1'b0;
        drop_idx   = li_reg;

        p    = lsel_reg ? q_prev_rd : s_prev_rd;
        n    = lsel_reg ? q_next_rd : s_next_rd;
        t    = lsel_reg ? q_tail_reg : s_tail_reg;
        used = {1'b0, lir_cnt_reg} + {1'b0, hir_cnt_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    addr_next     = ADDR_BITS'(s_axis_tdata);
                    ctr_next      = '0;
                    pend_next     = 1'b0;
                    found_next    = 1'b0;
                    x_next        = NIL;
                    free_next     = NIL;
                    hit_next      = 1'b0;
                    ev_valid_next = 1'b0;
                    ev_addr_next  = '0;
                    state_next    = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (pend_reg && valid_reg[idx_d_reg] && tag_rd_reg == addr_reg)
                begin
                    found_next = 1'b1;
                    x_next     = IW'(idx_d_reg);
                    xstat_next = stat_rd_reg;
                    state_next = ST_DISPATCH;
                end
                else
                begin
                    if (pend_reg && !valid_reg[idx_d_reg] && free_reg == NIL)
                    begin
                        free_next = IW'(idx_d_reg);
                    end
                    if (ctr_reg == NIL)
                    begin
                        state_next = ST_DISPATCH;
                    end
                    else
                    begin
                        ctr_next   = ctr_reg + IW'(1);
                        idx_d_next = ctr_reg[AW-1:0];
                        pend_next  = 1'b1;
                    end
                end
            end

            ST_DISPATCH:
            begin
                if (found_reg && xstat_reg[1:0] == K_LIR)
                begin
                    hit_next     = 1'b1;
                    top_ret_next = ST_H_PRUNE;
                    li_next      = x_reg[AW-1:0];
                    state_next   = ST_TOP_A;
                end
                else if (found_reg && xstat_reg[1:0] == K_HRES)
                begin
                    hit_next = 1'b1;
                    li_next  = x_reg[AW-1:0];
                    if (xstat_reg[ST_IN_S])
                    begin
                        state_next = ST_HR_A;
                    end
                    else
                    begin
                        top_ret_next = ST_HN_B;
                        state_next   = ST_TOP_A;
                    end
                end
                else
                begin
                    state_next = ST_M_CHK;
                end
            end

            // move x to the stack top
            ST_TOP_A:
            begin
                li_next    = x_reg[AW-1:0];
                st_we      = 1'b1;
                st_waddr   = x_reg[AW-1:0];
                st_wdata   = xstat_reg | 3'b100;
                xstat_next = xstat_reg | 3'b100;
                if (xstat_reg[ST_IN_S])
                begin
                    lsel_next     = LIST_S;
                    leaf_ret_next = ST_TOP_B;
                    state_next    = ST_RM;
                end
                else
                begin
                    state_next = ST_TOP_B;
                end
            end

            ST_TOP_B:
            begin
                li_next       = x_reg[AW-1:0];
                lsel_next     = LIST_S;
                leaf_ret_next = top_ret_reg;
                state_next    = ST_PU_A;
            end

            ST_HR_A:
            begin
                li_next       = x_reg[AW-1:0];
                lsel_next     = LIST_Q;
                leaf_ret_next = ST_HR_B;
                state_next    = ST_RM;
            end

            ST_HR_B:
            begin
                xstat_next   = {1'b1, K_LIR};
                lir_cnt_next = lir_cnt_reg + IW'(1);
                if (hir_cnt_reg != '0)
                begin
                    hir_cnt_next = hir_cnt_reg - IW'(1);
                end
                li_next      = x_reg[AW-1:0];
                top_ret_next = ST_HR_C;
                state_next   = ST_TOP_A;
            end

            ST_HR_C, ST_M_LIRCHK:
            begin
                if (KW'(lir_cnt_reg) > lim_eff)
                begin
                    demote_ret_next = ST_H_PRUNE;
                    state_next      = ST_DM_A;
                end
                else
                begin
                    state_next = ST_H_PRUNE;
                end
            end

            ST_HN_B:
            begin
                li_next       = x_reg[AW-1:0];
                lsel_next     = LIST_Q;
                leaf_ret_next = ST_HN_C;
                state_next    = ST_RM;
            end

            ST_HN_C, ST_M_QPUSH:
            begin
                li_next       = x_reg[AW-1:0];
                lsel_next     = LIST_Q;
                leaf_ret_next = ST_H_PRUNE;
                state_next    = ST_PU_A;
            end

            ST_H_PRUNE:
            begin
                prune_ret_next = ST_FINISH;
                state_next     = ST_PR_A;
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {6'b0, ev_addr_reg, ev_valid_reg, hit_reg};
                    state_next     = ST_IDLE;
                end
            end

            // miss: make room when the resident set is full
            ST_M_CHK:
            begin
                if ((KW + 1)'(used) >= (KW + 1)'(cap_eff))
                begin
                    if (q_head_reg == NIL)
                    begin
                        demote_ret_next = ST_M_EV;
                        state_next      = ST_DM_A;
                    end
                    else
                    begin
                        state_next = ST_M_EV;
                    end
                end
                else
                begin
                    state_next = ST_M_NEW;
                end
            end

            ST_M_EV:
            begin
                if (q_head_reg == NIL)
                begin
                    state_next = ST_M_NEW;
                end
                else
                begin
                    li_next    = q_head_reg[AW-1:0];
                    state_next = ST_M_EV2;
                end
            end

            ST_M_EV2:
            begin
                ev_valid_next = 1'b1;
                ev_addr_next  = 32'(tag_rd_reg);
                if (hir_cnt_reg != '0)
                begin
                    hir_cnt_next = hir_cnt_reg - IW'(1);
                end
                if (stat_rd_reg[ST_IN_S])
                begin
                    st_we    = 1'b1;
                    st_wdata = {1'b1, K_HNON};
                end
                else
                begin
                    drop = 1'b1;
                end
                lsel_next     = LIST_Q;
                leaf_ret_next = ST_M_NEW;
                state_next    = ST_RM;
            end

            ST_M_NEW:
            begin
                if (x_reg != NIL)
                begin
                    state_next = ST_M_XRD1;
                end
                else if (free_reg != NIL)
                begin
                    x_next     = free_reg;
                    state_next = ST_M_INS;
                end
                else if (s_head_reg != NIL)
                begin
                    li_next    = s_head_reg[AW-1:0];
                    state_next = ST_M_WALK;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            // table full: look for the non-resident HIR entry nearest the stack bottom
            ST_M_WALK:
            begin
                if (stat_rd_reg[1:0] == K_HNON)
                begin
                    drop          = 1'b1;
                    x_next        = IW'(li_reg);
                    lsel_next     = LIST_S;
                    leaf_ret_next = ST_M_INS;
                    state_next    = ST_RM;
                end
                else if (s_next_rd == NIL)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    li_next = s_next_rd[AW-1:0];
                end
            end

            ST_M_INS:
            begin
                tg_we    = 1'b1;
                st_we    = 1'b1;
                st_waddr = x_reg[AW-1:0];
                st_wdata = {1'b0, K_HNON};
                valid_next[x_reg[AW-1:0]] = 1'b1;
                state_next = ST_M_XRD1;
            end

            ST_M_XRD1:
            begin
                li_next    = x_reg[AW-1:0];
                state_next = ST_M_XRD2;
            end

            ST_M_XRD2:
            begin
                li_next = x_reg[AW-1:0];
                if (KW'(lir_cnt_reg) < lim_eff || stat_rd_reg[ST_IN_S])
                begin
                    xstat_next   = {stat_rd_reg[ST_IN_S], K_LIR};
                    lir_cnt_next = lir_cnt_reg + IW'(1);
                    top_ret_next = ST_M_LIRCHK;
                end
                else
                begin
                    xstat_next   = {1'b0, K_HRES};
                    hir_cnt_next = hir_cnt_reg + IW'(1);
                    top_ret_next = ST_M_QPUSH;
                end
                state_next = ST_TOP_A;
            end

            // demote the bottom LIR block of S into Q
            ST_DM_A:
            begin
                prune_ret_next = ST_DM_B;
                state_next     = ST_PR_A;
            end

            ST_DM_B:
            begin
                if (s_head_reg == NIL)
                begin
                    state_next = demote_ret_reg;
                end
                else
                begin
                    li_next       = s_head_reg[AW-1:0];
                    lsel_next     = LIST_S;
                    leaf_ret_next = ST_DM_C;
                    state_next    = ST_RM;
                end
            end

            ST_DM_C:
            begin
                st_we         = 1'b1;
                st_wdata      = {1'b0, K_HRES};
                lsel_next     = LIST_Q;
                leaf_ret_next = ST_DM_D;
                state_next    = ST_PU_A;
            end

            ST_DM_D:
            begin
                if (lir_cnt_reg != '0)
                begin
                    lir_cnt_next = lir_cnt_reg - IW'(1);
                end
                hir_cnt_next   = hir_cnt_reg + IW'(1);
                prune_ret_next = demote_ret_reg;
                state_next     = ST_PR_A;
            end

            // pop HIR blocks off the stack bottom until an LIR block is there
            ST_PR_A:
            begin
                if (s_head_reg == NIL)
                begin
                    state_next = prune_ret_reg;
                end
                else
                begin
                    li_next    = s_head_reg[AW-1:0];
                    state_next = ST_PR_B;
                end
            end

            ST_PR_B:
            begin
                if (stat_rd_reg[1:0] == K_LIR)
                begin
                    state_next = prune_ret_reg;
                end
                else
                begin
                    if (stat_rd_reg[1:0] == K_HNON)
                    begin
                        drop = 1'b1;
                    end
                    else
                    begin
                        st_we    = 1'b1;
                        st_wdata = {1'b0, stat_rd_reg[1:0]};
                    end
                    lsel_next     = LIST_S;
                    leaf_ret_next = ST_PR_A;
                    state_next    = ST_RM;
                end
            end

            // unlink li from the selected list; links were read in the previous cycle
            ST_RM:
            begin
                if (p == NIL)
                begin
                    if (lsel_reg == LIST_Q)
                    begin
                        q_head_next = n;
                    end
                    else
                    begin
                        s_head_next = n;
                    end
                end
                else
                begin
                    s_next_we  = (lsel_reg == LIST_S);
                    q_next_we  = (lsel_reg == LIST_Q);
                    next_waddr = p[AW-1:0];
                    next_wdata = n;
                end
                if (n == NIL)
                begin
                    if (lsel_reg == LIST_Q)
                    begin
                        q_tail_next = p;
                    end
                    else
                    begin
                        s_tail_next = p;
                    end
                end
                else
                begin
                    s_prev_we  = (lsel_reg == LIST_S);
                    q_prev_we  = (lsel_reg == LIST_Q);
                    prev_waddr = n[AW-1:0];
                    prev_wdata = p;
                end
                state_next = leaf_ret_reg;
            end

            // append li at the tail of the selected list
            ST_PU_A:
            begin
                s_prev_we  = (lsel_reg == LIST_S);
                q_prev_we  = (lsel_reg == LIST_Q);
                prev_waddr = li_reg;
                prev_wdata = t;
                if (t == NIL)
                begin
                    if (lsel_reg == LIST_Q)
                    begin
                        q_head_next = IW'(li_reg);
                    end
                    else
                    begin
                        s_head_next = IW'(li_reg);
                    end
                end
                else
                begin
                    s_next_we  = (lsel_reg == LIST_S);
                    q_next_we  = (lsel_reg == LIST_Q);
                    next_waddr = t[AW-1:0];
                    next_wdata = IW'(li_reg);
                end
                if (lsel_reg == LIST_Q)
                begin
                    q_tail_next = IW'(li_reg);
                end
                else
                begin
                    s_tail_next = IW'(li_reg);
                end
                state_next = ST_PU_B;
            end

            ST_PU_B:
            begin
                s_next_we  = (lsel_reg == LIST_S);
                q_next_we  = (lsel_reg == LIST_Q);
                next_waddr = li_reg;
                next_wdata = NIL;
                state_next = leaf_ret_reg;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (drop)
        begin
            valid_next[drop_idx] = 1'b0;
            st_we                = 1'b1;
            st_waddr             = drop_idx;
            st_wdata             = 3'b000;
            if (IW'(drop_idx) < free_reg)
            begin
                free_next = IW'(drop_idx);
            end
        end

        if (state_reg == ST_SCAN && ctr_reg != NIL)
        begin
            ts_raddr = ctr_reg[AW-1:0];
        end
        else
        begin
            ts_raddr = li_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tg_we)
        begin
            tag_mem[x_reg[AW-1:0]] <= addr_reg;
        end
        tag_rd_reg <= tag_mem[ts_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            stat_mem[st_waddr] <= st_wdata;
        end
        stat_rd_reg <= stat_mem[ts_raddr];
    end

    lirs_link_ram #(
        .DEPTH (TRACK_ENTRIES),
        .AW    (AW),
        .IW    (IW)
    ) u_s_links (
        .clk        (clk),
        .raddr      (li_next),
        .prev_rd    (s_prev_rd),
        .next_rd    (s_next_rd),
        .prev_we    (s_prev_we),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata),
        .next_we    (s_next_we),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata)
    );

    lirs_link_ram #(
        .DEPTH (TRACK_ENTRIES),
        .AW    (AW),
        .IW    (IW)
    ) u_q_links (
        .clk        (clk),
        .raddr      (li_next),
        .prev_rd    (q_prev_rd),
        .next_rd    (q_next_rd),
        .prev_we    (q_prev_we),
        .prev_waddr (prev_waddr),
        .prev_wdata (prev_wdata),
        .next_we    (q_next_we),
        .next_waddr (next_waddr),
        .next_wdata (next_wdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_blocks_reg <= CACHE_BLOCKS_W'(CACHE_BLOCKS_RESET);
            lir_limit_reg    <= LIR_LIMIT_W'(LIR_LIMIT_RESET);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_CACHE_BLOCKS)
            begin
                cache_blocks_reg <= cfg_data;
            end
            else if (cfg_index == REG_LIR_LIMIT)
            begin
                lir_limit_reg <= cfg_data[LIR_LIMIT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            leaf_ret_reg   <= ST_IDLE;
            prune_ret_reg  <= ST_IDLE;
            demote_ret_reg <= ST_IDLE;
            top_ret_reg    <= ST_IDLE;
            s_head_reg     <= NIL;
            s_tail_reg     <= NIL;
            q_head_reg     <= NIL;
            q_tail_reg     <= NIL;
            lir_cnt_reg    <= '0;
            hir_cnt_reg    <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            leaf_ret_reg   <= leaf_ret_next;
            prune_ret_reg  <= prune_ret_next;
            demote_ret_reg <= demote_ret_next;
            top_ret_reg    <= top_ret_next;
            s_head_reg     <= s_head_next;
            s_tail_reg     <= s_tail_next;
            q_head_reg     <= q_head_next;
            q_tail_reg     <= q_tail_next;
            lir_cnt_reg    <= lir_cnt_next;
            hir_cnt_reg    <= hir_cnt_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lsel_reg     <= lsel_next;
        li_reg       <= li_next;
        ctr_reg      <= ctr_next;
        pend_reg     <= pend_next;
        idx_d_reg    <= idx_d_next;
        addr_reg     <= addr_next;
        x_reg        <= x_next;
        found_reg    <= found_next;
        xstat_reg    <= xstat_next;
        free_reg     <= free_next;
        hit_reg      <= hit_next;
        ev_valid_reg <= ev_valid_next;
        ev_addr_reg  <= ev_addr_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- tb/lirs_checker.sv -----
// Checker for the LIRS core: watches both streams, predicts each access result, compares.
module lirs_checker
    import lirs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [31:0]            s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [39:0]            m_axis_tdata,
    output int                     fail_count,
    output int                     pending,
    output int                     hits_seen,
    output int                     evicts_seen
);

    localparam int N   = TRACK_ENTRIES_DEF;
    localparam int NIL = N;

    // same bit order as tdata: hit in bit 0
    typedef struct packed {
        logic [31:0] ev_addr;
        logic        ev_valid;
        logic        hit;
    } access_res_t;

    access_res_t res_q[$];

    logic [8:0]  cap_reg;
    logic [7:0]  lim_reg;
    logic [31:0] tags [N];
    bit          vld [N];
    logic [2:0]  stat [N];
    int          s_lk [N][2];
    int          q_lk [N][2];
    int          ends [4];
    int          n_lir;
    int          n_hres;

    function automatic int lk_get(int l, int i, int d);
        return l ? q_lk[i][d] : s_lk[i][d];
    endfunction

    function automatic void lk_set(int l, int i, int d, int v);
        if (l) q_lk[i][d] = v; else s_lk[i][d] = v;
    endfunction

    function automatic void unlink(int l, int i);
        int p, n;
        p = lk_get(l, i, 0);
        n = lk_get(l, i, 1);
        if (p >= NIL) ends[2*l] = n; else lk_set(l, p, 1, n);
        if (n >= NIL) ends[2*l+1] = p; else lk_set(l, n, 0, p);
    endfunction

    function automatic void append(int l, int i);
        int t;
        t = ends[2*l+1];
        lk_set(l, i, 0, t);
        lk_set(l, i, 1, NIL);
        if (t >= NIL) ends[2*l] = i; else lk_set(l, t, 1, i);
        ends[2*l+1] = i;
    endfunction

    function automatic logic [1:0] kind(int i);
        return stat[i][1:0];
    endfunction

    function automatic void prune();
        int h;
        h = ends[0];
        while (h < NIL && kind(h) != K_LIR) begin
            unlink(0, h);
            stat[h][ST_IN_S] = 1'b0;
            if (kind(h) == K_HNON) begin
                vld[h] = 0;
                stat[h] = '0;
            end
            h = ends[0];
        end
    endfunction

    function automatic void demote();
        int h;
        prune();
        h = ends[0];
        if (h >= NIL || kind(h) != K_LIR) return;
        unlink(0, h);
        stat[h] = {1'b0, K_HRES};
        append(1, h);
        if (n_lir > 0) n_lir--;
        n_hres++;
        prune();
    endfunction

    function automatic void raise_top(int i);
        if (stat[i][ST_IN_S]) unlink(0, i);
        append(0, i);
        stat[i][ST_IN_S] = 1'b1;
    endfunction

    function automatic void clear_state();
        cap_reg = 9'(CACHE_BLOCKS_RESET);
        lim_reg = 8'(LIR_LIMIT_RESET);
        for (int i = 0; i < N; i++)
        begin
            vld[i] = 0;
            stat[i] = '0;
            tags[i] = '0;
        end
        for (int k = 0; k < 4; k++) ends[k] = NIL;
        n_lir = 0;
        n_hres = 0;
    endfunction

    function automatic access_res_t predict_access(logic [31:0] a);
        access_res_t r;
        int cap, lim, x, e, s;
        r = '0;
        cap = cap_reg;
        lim = lim_reg;
        x = NIL;
        if (cap < 2) cap = 2;
        if (cap > N) cap = N;
        if (lim < 1) lim = 1;
        if (lim > cap - 1) lim = cap - 1;
        for (int i = 0; i < N; i++)
            if (vld[i] && tags[i] == a)
            begin
                x = i;
                break;
            end
        if (x < NIL && kind(x) == K_LIR) begin
            raise_top(x);
            prune();
            r.hit = 1'b1;
            return r;
        end
        if (x < NIL && kind(x) == K_HRES) begin
            if (stat[x][ST_IN_S]) begin
                unlink(1, x);
                stat[x] = {1'b1, K_LIR};
                raise_top(x);
                n_lir++;
                if (n_hres > 0) n_hres--;
                if (n_lir > lim) demote();
            end else begin
                raise_top(x);
                unlink(1, x);
                append(1, x);
            end
            prune();
            r.hit = 1'b1;
            return r;
        end
        if (n_lir + n_hres >= cap) begin
            if (ends[2] >= NIL) demote();
            if (ends[2] < NIL) begin
                e = ends[2];
                unlink(1, e);
                r.ev_valid = 1'b1;
                r.ev_addr = tags[e];
                if (n_hres > 0) n_hres--;
                if (stat[e][ST_IN_S]) stat[e] = {1'b1, K_HNON};
                else begin
                    vld[e] = 0;
                    stat[e] = '0;
                end
            end
        end
        if (x >= NIL) begin
            for (int i = 0; i < N; i++)
                if (!vld[i])
                begin
                    x = i;
                    break;
                end
            if (x >= NIL) begin
                s = ends[0];
                while (s < NIL && kind(s) != K_HNON) s = s_lk[s][1];
                if (s < NIL) begin
                    unlink(0, s);
                    vld[s] = 0;
                    stat[s] = '0;
                    x = s;
                end
            end
            if (x < NIL) begin
                tags[x] = a;
                vld[x] = 1;
                stat[x] = {1'b0, K_HNON};
            end
        end
        if (x < NIL) begin
            if (n_lir < lim || stat[x][ST_IN_S]) begin
                stat[x][1:0] = K_LIR;
                raise_top(x);
                n_lir++;
                if (n_lir > lim) demote();
            end else begin
                stat[x] = {1'b0, K_HRES};
                raise_top(x);
                append(1, x);
                n_hres++;
            end
            prune();
        end
        return r;
    endfunction

    access_res_t got, want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            clear_state();
            res_q.delete();
            fail_count <= 0;
            pending <= 0;
            hits_seen <= 0;
            evicts_seen <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_CACHE_BLOCKS) cap_reg = cfg_data;
                else if (cfg_index == REG_LIR_LIMIT) lim_reg = cfg_data[7:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                res_q.push_back(predict_access(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[33:0];
                if (res_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("chk: unexpected result %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = res_q.pop_front();
                    if (got != want || m_axis_tdata[39:34] != 0) begin
                        if (fail_count < 10)
                            $display("chk: exp hit=%0b ev=%0b addr=%h, got %h",
                                     want.hit, want.ev_valid, want.ev_addr, m_axis_tdata);
                        fail_count <= fail_count + 1;
                    end
                    if (want.hit) hits_seen <= hits_seen + 1;
                    if (want.ev_valid) evicts_seen <= evicts_seen + 1;
                end
            end
            pending <= res_q.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the LIRS core: clock, reset, access stimulus and verdict.
module tb;
    import lirs_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [31:0]            s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [39:0]            m_axis_tdata;
    int                     fail_count;
    int                     pending;
    int                     hits_seen;
    int                     evicts_seen;
    int                     cycles;
    int                     sent;
    bit                     hold_off;
    bit                     no_gaps;

    lirs_replacement_policy_core i_dut (.*);

    lirs_checker i_chk (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog: reports errors and stops the run if it goes on too long
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2500000) begin
            $display("tb: errors");
            $finish;
        end
    end

    // result side: random stalls, always ready with no_gaps, one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off) m_axis_tready <= 1'b0;
        else if (no_gaps) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 6) == 0) || ($urandom_range(0, 1) == 1);
    end

    // tvalid stays up after a transaction until the next gap or drain lowers it
    task automatic access_block(logic [31:0] a);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= a;
        do @(posedge clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0 || s_axis_tvalid) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // accesses drawn from a working set around the cache size, with some noise
    task automatic random_phase(int count, int span, logic [31:0] base);
        logic [31:0] a;
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 9))
                0:       a = $urandom();
                1, 2, 3: a = base + $urandom_range(0, span / 3);
                default: a = base + $urandom_range(0, span);
            endcase
            access_block(a);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cycles        = 0;
        sent          = 0;
        hold_off      = 1'b0;
        no_gaps       = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: tiny cache, extremes of address, hits, evictions, promotion
        write_reg(REG_CACHE_BLOCKS, 9'd3);
        write_reg(REG_LIR_LIMIT, 9'd1);
        access_block(32'h0);
        access_block(32'hFFFF_FFFF);
        access_block(32'h0);
        access_block(32'hAAAA_5555);
        access_block(32'h5555_AAAA);
        access_block(32'hFFFF_FFFF);
        access_block(32'hAAAA_5555);
        access_block(32'h1);
        access_block(32'h0);
        access_block(32'h8000_0000);
        access_block(32'h5555_AAAA);
        access_block(32'h1);
        drain();
        // out-of-range settings get clamped; lowering forces demotion with empty queue
        write_reg(REG_CACHE_BLOCKS, 9'd0);
        write_reg(REG_LIR_LIMIT, 9'd0);
        for (int k = 0; k < 6; k++) access_block(32'h10 + k % 3);
        drain();
        write_reg(REG_CACHE_BLOCKS, 9'd511);
        write_reg(REG_LIR_LIMIT, 9'd255);
        for (int k = 0; k < 6; k++) access_block(32'h20 + k);
        drain();

        // default-size phase with a long receiver hold-off to fill the pipe
        write_reg(REG_CACHE_BLOCKS, 9'd64);
        write_reg(REG_LIR_LIMIT, 9'd57);
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            random_phase(400, 90, 32'h1000);
        join
        drain();
        // small cache, lir limit at the top of its clamp
        write_reg(REG_CACHE_BLOCKS, 9'd8);
        write_reg(REG_LIR_LIMIT, 9'd200);
        random_phase(300, 14, 32'h2000);
        drain();
        // lower limit under a populated table with back-to-back accesses, then minimum cache
        write_reg(REG_LIR_LIMIT, 9'd2);
        no_gaps = 1'b1;
        random_phase(200, 12, 32'h2000);
        no_gaps = 1'b0;
        drain();
        write_reg(REG_CACHE_BLOCKS, 9'd2);
        random_phase(200, 6, 32'h3000);
        drain();
        // full-size cache with an address pool larger than the table
        write_reg(REG_CACHE_BLOCKS, 9'd256);
        write_reg(REG_LIR_LIMIT, 9'd128);
        random_phase(600, 400, 32'hFFFF_FE00);
        drain();

        $display("tb: %0d accesses checked, %0d hits, %0d evictions, sizes 2..256",
                 sent, hits_seen, evicts_seen);
        if (fail_count == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/lirs_pkg.sv
hw/rtl/lirs_link_ram.sv
hw/rtl/lirs_replacement_policy_core.sv
tb/lirs_checker.sv
tb/tb.sv
